// File: rtl/best_fit_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// best-fit allocator assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BFFLA_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFFLA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bffla_pkg.sv
// ----------------------------------------------------------------------------
// best-fit allocator package
// field widths, opcodes, status codes and controller/datapath link types
// ----------------------------------------------------------------------------
package bffla_pkg;

  localparam int REQ_W    = 8;
  localparam int UOFF_W   = 7;
  localparam int STATUS_W = 2;
  // request plus header, header is at most 256 bytes
  localparam int TOTAL_W  = 9;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                take;
    logic                scan_init;
    logic                scan_run;
    logic                carve;
    logic                fr_write;
    logic                load;
    logic [STATUS_W-1:0] code;
  } bffla_cmd_t;

  typedef struct packed {
    logic op_free;
    logic too_large;
    logic list_full;
    logic fr_ok;
    logic scan_done;
    logic found;
    logic out_room;
  } bffla_sts_t;

endpackage

// File: rtl/bffla_if.sv
// ----------------------------------------------------------------------------
// best-fit allocator channels
// request and result valid/ready channels with their payloads
// ----------------------------------------------------------------------------
interface bffla_in_if import bffla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [REQ_W-1:0]  request_bytes;
  logic [UOFF_W-1:0] user_offset_in;

  modport source (output valid, operation, request_bytes, user_offset_in, input ready);
  modport sink   (input valid, operation, request_bytes, user_offset_in, output ready);
endinterface

interface bffla_out_if import bffla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [UOFF_W-1:0]   user_offset_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, user_offset_out, status, input ready);
  modport sink   (input valid, user_offset_out, status, output ready);
endinterface

// File: rtl/bffla_ram.sv
// ----------------------------------------------------------------------------
// generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bffla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bffla_ctrl.sv
// ----------------------------------------------------------------------------
// best-fit allocator controller
// sequences decode, list scan, carve or append, and result hand-off
// ----------------------------------------------------------------------------
module bffla_ctrl import bffla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output bffla_cmd_t cmd,
  input  bffla_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_CARVE  = 3'd3;
  localparam logic [2:0] S_FWRITE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op_free) begin
          if (sts.list_full) begin
            code_nxt  = ST_FULL;
            state_nxt = S_DONE;
          end else if (sts.fr_ok) begin
            state_nxt = S_FWRITE;
          end else begin
            // out-of-heap free is dropped quietly
            code_nxt  = ST_OK;
            state_nxt = S_DONE;
          end
        end else if (sts.too_large) begin
          code_nxt  = ST_TOO_LARGE;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            state_nxt = S_CARVE;
          end else begin
            code_nxt  = ST_NO_FIT;
            state_nxt = S_DONE;
          end
        end
      end
      S_CARVE: begin
        cmd.carve = 1'b1;
        code_nxt  = ST_OK;
        state_nxt = S_DONE;
      end
      S_FWRITE: begin
        cmd.fr_write = 1'b1;
        code_nxt     = ST_OK;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_room) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/bffla_dp.sv
// ----------------------------------------------------------------------------
// best-fit allocator datapath
// free-list memory, size record memory, scan compare and result register
// ----------------------------------------------------------------------------
module bffla_dp import bffla_pkg::*; #(
  parameter int HEAP_BYTES   = 128,
  parameter int LIST_DEPTH   = 64,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bffla_cmd_t          cmd,
  output bffla_sts_t          sts,
  input  logic                operation,
  input  logic [REQ_W-1:0]    request_bytes,
  input  logic [UOFF_W-1:0]   user_offset_in,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [UOFF_W-1:0]   user_offset_out,
  output logic [STATUS_W-1:0] status
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int FW = $clog2(HEAP_BYTES + 1);
  // start plus free bytes of any entry stays below twice the heap
  localparam int SW = $clog2(2 * HEAP_BYTES);
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int LW = SW + FW;

  logic                op_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [UOFF_W-1:0]   uoff_r;
  logic [CW-1:0]       count_r;
  logic                e0_wr_r;
  logic [CW-1:0]       iss_r;
  logic                cmp_vld_r;
  logic [IW-1:0]       cmp_idx_r;
  logic                found_r;
  logic [IW-1:0]       best_idx_r;
  logic [SW-1:0]       best_start_r;
  logic [FW-1:0]       best_free_r;
  logic [UOFF_W-1:0]   off_r;
  logic                out_valid_r;
  logic [UOFF_W-1:0]   out_offset_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [LW-1:0]       list_rdata;
  logic [LW-1:0]       list_wdata;
  logic [IW-1:0]       list_waddr;
  logic                list_we;
  logic [FW-1:0]       st_rdata;
  logic                st_we;
  logic [7:0]          fr_start;
  logic [SW-1:0]       ent_start;
  logic [FW-1:0]       ent_free;
  logic                iss_lt;
  logic                hit;
  logic [SW:0]         carve_sum;
  logic [FW-1:0]       carve_free;
  logic [9:0]          off_sum;
  logic                in_heap;

  assign fr_start = 8'(uoff_r) - 8'(HEADER_BYTES);
  assign iss_lt   = (iss_r < count_r);

  // entry 0 reads as the whole heap until it is first carved
  always_comb begin
    if ((cmp_idx_r == '0) && !e0_wr_r) begin
      ent_start = '0;
      ent_free  = FW'(HEAP_BYTES);
    end else begin
      ent_start = list_rdata[LW-1:FW];
      ent_free  = list_rdata[FW-1:0];
    end
  end

  assign hit = (TOTAL_W'(ent_free) >= total_r) && (!found_r || (ent_free < best_free_r));

  assign carve_sum  = (SW+1)'(best_start_r) + (SW+1)'(total_r);
  assign carve_free = best_free_r - FW'(total_r);
  assign off_sum    = 10'(best_start_r) + 10'(HEADER_BYTES);
  assign in_heap    = (best_start_r < SW'(HEAP_BYTES));

  assign list_we    = cmd.carve | cmd.fr_write;
  assign list_waddr = cmd.carve ? best_idx_r : count_r[IW-1:0];
  assign list_wdata = cmd.carve ? {carve_sum[SW-1:0], carve_free}
                                : {SW'(fr_start), st_rdata};
  assign st_we      = cmd.carve && in_heap;

  bffla_ram #(.WIDTH(LW), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (iss_r[IW-1:0]),
    .rdata (list_rdata)
  );

  bffla_ram #(.WIDTH(FW), .DEPTH(HEAP_BYTES)) u_size_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (best_start_r[AW-1:0]),
    .wdata (total_r[FW-1:0]),
    .raddr (fr_start[AW-1:0]),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(1);
      e0_wr_r     <= 1'b0;
      iss_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        iss_r     <= '0;
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_vld_r <= iss_lt;
        if (iss_lt) begin
          iss_r <= iss_r + CW'(1);
        end
        if (cmp_vld_r && hit) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.carve && (best_idx_r == '0)) begin
        e0_wr_r <= 1'b1;
      end
      if (cmd.fr_write) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= operation;
      total_r <= TOTAL_W'(request_bytes) + TOTAL_W'(HEADER_BYTES);
      uoff_r  <= user_offset_in;
      off_r   <= '0;
    end
    if (cmd.scan_run) begin
      cmp_idx_r <= iss_r[IW-1:0];
      if (cmp_vld_r && hit) begin
        best_idx_r   <= cmp_idx_r;
        best_start_r <= ent_start;
        best_free_r  <= ent_free;
      end
    end
    if (cmd.carve) begin
      off_r <= off_sum[UOFF_W-1:0];
    end
    if (cmd.load) begin
      out_offset_r <= off_r;
      out_status_r <= cmd.code;
    end
  end

  assign sts.op_free   = (op_r == OP_FREE);
  assign sts.too_large = (total_r > TOTAL_W'(HEAP_BYTES));
  assign sts.list_full = (count_r == CW'(LIST_DEPTH));
  assign sts.fr_ok     = (uoff_r >= UOFF_W'(HEADER_BYTES)) && (fr_start < 8'(HEAP_BYTES));
  assign sts.scan_done = !iss_lt && !cmp_vld_r;
  assign sts.found     = found_r;
  assign sts.out_room  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign user_offset_out = out_offset_r;
  assign status          = out_status_r;

endmodule

// File: rtl/best_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// best-fit free-list allocator
// allocates and frees header-prefixed blocks of a byte heap, best fit first
// ----------------------------------------------------------------------------
//   channel   dir  payload                                   handshake
//   in_ch     in   operation, request_bytes, user_offset_in  valid/ready
//   out_ch    out  user_offset_out, status                   valid/ready
//
// allocate: the time from request to result is set by the list scan,
//   which reads one free-list entry per cycle from the single-port-read list memory
// no fitting entry: full scan, no carve; free, oversize, full list and out-of-heap
//   free skip the scan; the block returns to idle before it takes the next request
// reset: synchronous, no clearing pass; entry 0 is flagged as the whole heap
// a held result does not block the next request; work stalls only at hand-off
module best_fit_free_list_allocator import bffla_pkg::*; #(
  parameter int HEAP_BYTES   = 128,
  parameter int LIST_DEPTH   = 64,
  parameter int HEADER_BYTES = 4
) (
  input logic            clk,
  input logic            rst_n,
  bffla_in_if.sink       in_ch,
  bffla_out_if.source    out_ch
);

  bffla_cmd_t cmd;
  bffla_sts_t sts;

  bffla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bffla_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .LIST_DEPTH   (LIST_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (in_ch.operation),
    .request_bytes   (in_ch.request_bytes),
    .user_offset_in  (in_ch.user_offset_in),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .user_offset_out (out_ch.user_offset_out),
    .status          (out_ch.status)
  );

endmodule

// File: rtl/bffla_checker.sv
// ----------------------------------------------------------------------------
// best-fit allocator port checker
// watches the top-level channels and tracks requests in flight
// ----------------------------------------------------------------------------
`include "best_fit_free_list_allocator_macros.svh"

module bffla_checker import bffla_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [UOFF_W-1:0]   user_offset_out,
  input logic [STATUS_W-1:0] status
);

  logic [2:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken whose result has not left yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  `BFFLA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_acc, !in_ready, "request taken while busy")
  `BFFLA_ASSERT_SAME(a_err_zero_off, clk, rst_n, out_valid && (status != ST_OK), user_offset_out == '0, "error result with nonzero offset")
  `BFFLA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(user_offset_out), "result changed while stalled")
  `BFFLA_ASSERT_SAME(a_no_phantom, clk, rst_n, out_valid, pend_r != '0, "result without a request")
  `BFFLA_ASSERT_SAME(a_pend_bound, clk, rst_n, 1'b1, pend_r <= 3'd2, "more than two requests in flight")

endmodule

bind best_fit_free_list_allocator bffla_checker u_bffla_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .user_offset_out (out_ch.user_offset_out),
  .status          (out_ch.status)
);

// File: verif/best_fit_free_list_allocator_checker.sv
// ----------------------------------------------------------------------------
// best-fit allocator result checker
// watches both channels, keeps its own copy of the free list and the block
// size records, predicts every reply and compares it field by field
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_checker import bffla_pkg::*; #(
  parameter int HEAP_BYTES   = 128,
  parameter int LIST_DEPTH   = 64,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_operation,
  input  logic [REQ_W-1:0]    in_request_bytes,
  input  logic [UOFF_W-1:0]   in_user_offset_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [UOFF_W-1:0]   out_user_offset_out,
  input  logic [STATUS_W-1:0] out_status,
  output int                  error_count,
  output int                  pending_count,
  output int                  placed_count,
  output int                  no_fit_count,
  output int                  too_large_count,
  output int                  list_full_count
);

  typedef struct packed {
    logic [UOFF_W-1:0]   user_offset;
    logic [STATUS_W-1:0] status;
  } reply_t;

  reply_t pending_replies[$];
  reply_t want;

  // start is one bit wider than an offset: a fully carved entry sits at the heap end
  logic [7:0] seg_start [LIST_DEPTH];
  logic [7:0] seg_bytes [LIST_DEPTH];
  int         seg_count;
  logic [7:0] block_size [HEAP_BYTES];

  function automatic reply_t heap_step(logic op, logic [REQ_W-1:0] req,
                                       logic [UOFF_W-1:0] uoff);
    reply_t             r;
    logic [TOTAL_W-1:0] total;
    int                 best;
    logic [7:0]         blk_start;
    r.user_offset = '0;
    r.status      = ST_OK;
    if (op == OP_ALLOC) begin
      total = TOTAL_W'(req) + TOTAL_W'(HEADER_BYTES);
      if (total > HEAP_BYTES) begin
        r.status = ST_TOO_LARGE;
      end else begin
        best = -1;
        // strict less-than keeps the lowest index on a tie
        for (int i = 0; i < seg_count; i++) begin
          if (seg_bytes[i] >= total && (best < 0 || seg_bytes[i] < seg_bytes[best])) begin
            best = i;
          end
        end
        if (best < 0) begin
          r.status = ST_NO_FIT;
        end else begin
          blk_start = seg_start[best];
          if (blk_start < HEAP_BYTES) begin
            block_size[blk_start] = 8'(total);
          end
          seg_start[best] = blk_start + 8'(total);
          seg_bytes[best] = seg_bytes[best] - 8'(total);
          r.user_offset   = UOFF_W'(blk_start + HEADER_BYTES);
        end
      end
    end else begin
      if (seg_count >= LIST_DEPTH) begin
        r.status = ST_FULL;
      end else if (uoff >= HEADER_BYTES && uoff - HEADER_BYTES < HEAP_BYTES) begin
        seg_start[seg_count] = 8'(uoff - HEADER_BYTES);
        seg_bytes[seg_count] = block_size[uoff - HEADER_BYTES];
        seg_count++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        seg_start[i] = '0;
        seg_bytes[i] = '0;
      end
      for (int i = 0; i < HEAP_BYTES; i++) begin
        block_size[i] = '0;
      end
      seg_bytes[0] = 8'(HEAP_BYTES);
      seg_count    = 1;
      pending_replies.delete();
      error_count     = 0;
      placed_count    = 0;
      no_fit_count    = 0;
      too_large_count = 0;
      list_full_count = 0;
      pending_count  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          error_count++;
          $error("reply with no request outstanding: user_offset_out %0d status %0d",
                 out_user_offset_out, out_status);
        end else begin
          want = pending_replies.pop_front();
          if (out_user_offset_out !== want.user_offset) begin
            error_count++;
            $error("user_offset_out: expected %0d, got %0d",
                   want.user_offset, out_user_offset_out);
          end
          if (out_status !== want.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
          case (want.status)
            ST_OK:        if (want.user_offset != 0) placed_count++;
            ST_NO_FIT:    no_fit_count++;
            ST_TOO_LARGE: too_large_count++;
            ST_FULL:      list_full_count++;
            default: ;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        pending_replies.push_back(heap_step(in_operation, in_request_bytes,
                                            in_user_offset_in));
      end
      pending_count <= pending_replies.size();
    end
  end

endmodule

// File: verif/best_fit_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// best-fit allocator testbench
// directed corner requests, then random allocate/free traffic freeing blocks
// seen placed or below the header, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_test;
  import bffla_pkg::*;

  localparam int HEAP_BYTES   = 128;
  localparam int LIST_DEPTH   = 64;
  localparam int HEADER_BYTES = 4;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;

  int error_count;
  int pending_count;
  int placed_count;
  int no_fit_count;
  int too_large_count;
  int list_full_count;
  int ready_hold;

  // user offsets of blocks seen placed, picked for frees
  bit offset_seen [128];

  bffla_in_if  in_ch ();
  bffla_out_if out_ch ();

  best_fit_free_list_allocator #(
    .HEAP_BYTES   (HEAP_BYTES),
    .LIST_DEPTH   (LIST_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  best_fit_free_list_allocator_checker #(
    .HEAP_BYTES   (HEAP_BYTES),
    .LIST_DEPTH   (LIST_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_operation        (in_ch.operation),
    .in_request_bytes    (in_ch.request_bytes),
    .in_user_offset_in   (in_ch.user_offset_in),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_user_offset_out (out_ch.user_offset_out),
    .out_status          (out_ch.status),
    .error_count         (error_count),
    .pending_count       (pending_count),
    .placed_count        (placed_count),
    .no_fit_count        (no_fit_count),
    .too_large_count     (too_large_count),
    .list_full_count     (list_full_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [UOFF_W-1:0] pick_placed_offset();
    int total;
    int k;
    total = 0;
    for (int i = 0; i < 128; i++) begin
      if (offset_seen[i]) total++;
    end
    if (total == 0) return '0;
    k = $urandom_range(0, total - 1);
    for (int i = 0; i < 128; i++) begin
      if (offset_seen[i]) begin
        if (k == 0) return UOFF_W'(i);
        k--;
      end
    end
    return '0;
  endfunction

  // an allocate that came back ok marks its user offset as seen
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.status == ST_OK &&
        out_ch.user_offset_out >= HEADER_BYTES) begin
      offset_seen[out_ch.user_offset_out] <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 65);
      ready_hold   <= idle_gap();
    end
  end

  task automatic issue_request(logic op, logic [REQ_W-1:0] req, logic [UOFF_W-1:0] uoff);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.request_bytes  <= req;
    in_ch.user_offset_in <= uoff;
    do @(posedge clk); while (!in_ch.ready);
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int               sent;
    int               roll;
    logic             op;
    logic [REQ_W-1:0] req;
    logic [UOFF_W-1:0] uoff;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_ALLOC;
    in_ch.request_bytes  = '0;
    in_ch.user_offset_in = '0;
    out_ch.ready         = 1'b0;
    no_idle              = 1'b0;
    ready_hold           = 0;
    rst_n                = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // oversize twice, exact whole-heap fit, then no fit on an empty entry
    issue_request(OP_ALLOC, 8'd255, 7'd127);
    issue_request(OP_ALLOC, 8'd125, 7'd0);
    issue_request(OP_ALLOC, 8'd124, 7'd85);
    issue_request(OP_ALLOC, 8'd0,   7'd42);
    // frees below the header are ignored, then the whole-heap block is freed
    issue_request(OP_FREE,  8'd255, 7'd0);
    issue_request(OP_FREE,  8'd170, 7'd3);
    issue_request(OP_FREE,  8'd0,   7'd4);
    issue_request(OP_ALLOC, 8'd0,   7'd127);
    issue_request(OP_ALLOC, 8'd10,  7'd0);
    issue_request(OP_ALLOC, 8'd50,  7'd0);
    // double free gives two equal entries, the lower index must win
    issue_request(OP_FREE,  8'd85,  7'd8);
    issue_request(OP_FREE,  8'd0,   7'd8);
    issue_request(OP_ALLOC, 8'd10,  7'd21);
    issue_request(OP_ALLOC, 8'd53,  7'd0);
    issue_request(OP_ALLOC, 8'd52,  7'd106);
    issue_request(OP_FREE,  8'd255, 7'd76);
    issue_request(OP_FREE,  8'd1,   7'd22);
    issue_request(OP_ALLOC, 8'd128, 7'd64);
    issue_request(OP_ALLOC, 8'd1,   7'd1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle <= ((sent / 150) % 4) == 3;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        op  = OP_FREE;
        req = REQ_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) uoff = UOFF_W'($urandom_range(0, HEADER_BYTES - 1));
        else uoff = pick_placed_offset();
      end else begin
        op   = OP_ALLOC;
        uoff = UOFF_W'($urandom_range(0, 127));
        roll = $urandom_range(0, 99);
        if (roll < 75) req = REQ_W'($urandom_range(0, 24));
        else if (roll < 90) req = REQ_W'($urandom_range(25, 124));
        else req = REQ_W'($urandom_range(125, 255));
      end
      // frees that the block ignores do not count
      if (op == OP_ALLOC || uoff >= HEADER_BYTES) sent++;
      issue_request(op, req, uoff);
    end
    in_ch.valid <= 1'b0;

    // let the checker count the last request before waiting on it
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("random phase: %0d counted requests; blocks placed %0d, no fitting entry %0d",
             sent, placed_count, no_fit_count);
    $display("oversize requests %0d, frees refused on a full list %0d",
             too_large_count, list_full_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1500000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/bffla_pkg.sv
rtl/bffla_if.sv
rtl/bffla_ram.sv
rtl/bffla_ctrl.sv
rtl/bffla_dp.sv
rtl/best_fit_free_list_allocator.sv
rtl/bffla_checker.sv
verif/best_fit_free_list_allocator_checker.sv
verif/best_fit_free_list_allocator_test.sv
